// ===== hdl/lidar_angular_window_stats_core_defines.svh =====
// Assertion macros shared by the lidar angular window statistics core.
`ifndef LIDAR_ANGULAR_WINDOW_STATS_CORE_DEFINES_SVH
`define LIDAR_ANGULAR_WINDOW_STATS_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LAWSC_ASSERT_SAME(label, clock, reset, pre, post) \
  label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
    else $error("lawsc: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define LAWSC_ASSERT_NEXT(label, clock, reset, pre, post) \
  label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
    else $error("lawsc: next-cycle check failed");

`endif

// ===== hdl/lawsc_pkg.sv =====
// Shared types and constants of the lidar angular window statistics core.
package lawsc_pkg;

  localparam int RANGE_W     = 16;
  localparam int ANGLE_W     = 16;
  localparam int CFG_W       = 16;
  localparam int COUNT_OUT_W = 13;
  localparam int QUO_W       = RANGE_W;
  localparam int STEP_W      = $clog2(QUO_W);
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_START     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_END       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BAND_LOW         = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BAND_HIGH        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SCAN_START_ANGLE = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_STEP       = 3'd5;

  typedef struct packed {
    logic [ANGLE_W-1:0] window_start;
    logic [ANGLE_W-1:0] window_end;
    logic [RANGE_W-1:0] band_low;
    logic [RANGE_W-1:0] band_high;
    logic [ANGLE_W-1:0] scan_start_angle;
    logic [ANGLE_W-1:0] angle_step;
  } cfg_t;

  typedef struct packed {
    logic take;
    logic clear;
  } acc_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hdl/lawsc_accum.sv =====
// Per-sample bearing tracking, window test and running statistics.
module lawsc_accum #(
  parameter int MAX_SAMPLES = 4096,
  parameter int CNT_W       = 13
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lawsc_pkg::acc_ctl_t            ctl,
  input  lawsc_pkg::cfg_t                cfg,
  input  logic [lawsc_pkg::RANGE_W-1:0]  range_mm,
  input  logic                           sample_valid,
  output logic [lawsc_pkg::RANGE_W-1:0]  running_min,
  output logic                           any_in_window,
  output logic [lawsc_pkg::RANGE_W+CNT_W-1:0] range_sum,
  output logic [CNT_W-1:0]               in_window_count,
  output logic [CNT_W-1:0]               in_band_count,
  output logic                           overflowed
);

  logic [lawsc_pkg::ANGLE_W-1:0] sample_bearing;
  logic [CNT_W-1:0]              sample_index;
  logic [lawsc_pkg::ANGLE_W-1:0] bearing;
  logic                          full;
  logic                          in_win;
  logic                          hit;
  logic                          in_band;

  // Until the first sample of a scan is taken, the bearing follows the start register.
  assign bearing = (sample_index == '0) ? cfg.scan_start_angle : sample_bearing;
  assign full    = sample_index >= CNT_W'(MAX_SAMPLES);

  always_comb begin
    if (cfg.window_start <= cfg.window_end) begin
      in_win = (bearing >= cfg.window_start) && (bearing <= cfg.window_end);
    end else begin
      in_win = (bearing >= cfg.window_start) || (bearing <= cfg.window_end);
    end
  end

  assign hit     = sample_valid && (range_mm != '0) && in_win;
  assign in_band = (range_mm >= cfg.band_low) && (range_mm <= cfg.band_high);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      sample_bearing  <= '0;
      sample_index    <= '0;
      running_min     <= '0;
      any_in_window   <= 1'b0;
      range_sum       <= '0;
      in_window_count <= '0;
      in_band_count   <= '0;
      overflowed      <= 1'b0;
    end else if (ctl.take) begin
      if (full) begin
        overflowed <= 1'b1;
      end else begin
        sample_bearing <= bearing + cfg.angle_step;
        sample_index   <= sample_index + 1'b1;
        if (hit) begin
          if (!any_in_window || (range_mm < running_min)) begin
            running_min <= range_mm;
          end
          any_in_window   <= 1'b1;
          range_sum       <= range_sum + {{CNT_W{1'b0}}, range_mm};
          in_window_count <= in_window_count + 1'b1;
          if (in_band) begin
            in_band_count <= in_band_count + 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== hdl/lawsc_div.sv =====
// Shared compare-and-subtract unit that forms the mean one quotient bit per cycle.
module lawsc_div #(
  parameter int DEN_W = 13
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [DEN_W+lawsc_pkg::QUO_W-1:0] num,
  input  logic [DEN_W-1:0]             den,
  output logic [lawsc_pkg::QUO_W-1:0]  quo,
  output lawsc_pkg::div_stat_t         stat
);

  localparam int NUM_W = DEN_W + lawsc_pkg::QUO_W;

  logic [NUM_W-1:0]             rem;
  logic [NUM_W-1:0]             dsh;
  logic [NUM_W:0]               diff;
  logic                         ge;
  logic [lawsc_pkg::STEP_W-1:0] step;

  // The quotient is known to fit, since every summed range is below the quotient range.
  assign diff = {1'b0, rem} - {1'b0, dsh};
  assign ge   = !diff[NUM_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      stat.busy <= 1'b0;
      stat.done <= 1'b0;
    end else if (start) begin
      stat.busy <= 1'b1;
      stat.done <= 1'b0;
    end else if (stat.busy && (step == lawsc_pkg::STEP_W'(lawsc_pkg::QUO_W - 1))) begin
      stat.busy <= 1'b0;
      stat.done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dsh  <= {1'b0, den, {(lawsc_pkg::QUO_W-1){1'b0}}};
      quo  <= '0;
      step <= '0;
    end else if (stat.busy) begin
      if (ge) begin
        rem <= diff[NUM_W-1:0];
      end
      quo  <= {quo[lawsc_pkg::QUO_W-2:0], ge};
      dsh  <= dsh >> 1;
      step <= step + 1'b1;
    end
  end

endmodule

// ===== hdl/lidar_angular_window_stats_core.sv =====
// Top level of the lidar angular window statistics core: sequencer, registers and result.
// A sample without the last mark is taken and leaves in_ready high.
// A last sample drops in_ready; its result passes the start state and the
// 16-step shared subtractor that forms the mean, then is loaded once the output is free.
// The next item is taken in the cycle after the result is loaded into the output register.
// Synchronous reset sets state, config and divider status and clears scan and out_valid.
module lidar_angular_window_stats_core #(
  parameter int MAX_SAMPLES = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [lawsc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [lawsc_pkg::CFG_W-1:0]        cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [lawsc_pkg::RANGE_W-1:0]      range_mm,
  input  logic                               sample_valid,
  input  logic                               last_sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               min_found,
  output logic [lawsc_pkg::RANGE_W-1:0]      min_range_out,
  output logic [lawsc_pkg::RANGE_W-1:0]      mean_range_out,
  output logic [lawsc_pkg::COUNT_OUT_W-1:0]  window_points,
  output logic [lawsc_pkg::COUNT_OUT_W-1:0]  band_points,
  output logic                               scan_overflow
);

  `include "lidar_angular_window_stats_core_defines.svh"

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int EXT_W = CNT_W + lawsc_pkg::COUNT_OUT_W;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_START = 3'b010,
    S_DIV   = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  lawsc_pkg::cfg_t      cfg;
  lawsc_pkg::acc_ctl_t  acc_ctl;
  lawsc_pkg::div_stat_t div_stat;

  logic [lawsc_pkg::RANGE_W-1:0]       acc_min;
  logic                                acc_any;
  logic [lawsc_pkg::RANGE_W+CNT_W-1:0] acc_sum;
  logic [CNT_W-1:0]                    acc_count;
  logic [CNT_W-1:0]                    acc_band;
  logic                                acc_ovf;
  logic [lawsc_pkg::QUO_W-1:0]         div_quo;
  logic [EXT_W-1:0]                    count_ext;
  logic [EXT_W-1:0]                    band_ext;

  logic in_take;
  logic out_free;
  logic load;

  assign in_ready = (state == S_IDLE);
  assign in_take  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign load     = (state == S_DIV) && div_stat.done && out_free;

  assign acc_ctl.take  = in_take;
  assign acc_ctl.clear = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_start     <= '0;
      cfg.window_end       <= '1;
      cfg.band_low         <= '0;
      cfg.band_high        <= '1;
      cfg.scan_start_angle <= '0;
      cfg.angle_step       <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lawsc_pkg::REG_WINDOW_START:     cfg.window_start     <= cfg_data;
        lawsc_pkg::REG_WINDOW_END:       cfg.window_end       <= cfg_data;
        lawsc_pkg::REG_BAND_LOW:         cfg.band_low         <= cfg_data;
        lawsc_pkg::REG_BAND_HIGH:        cfg.band_high        <= cfg_data;
        lawsc_pkg::REG_SCAN_START_ANGLE: cfg.scan_start_angle <= cfg_data;
        lawsc_pkg::REG_ANGLE_STEP:       cfg.angle_step       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_take && last_sample) begin
          state_next = S_START;
        end
      end
      S_START: state_next = S_DIV;
      S_DIV: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  lawsc_accum #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .CNT_W       (CNT_W)
  ) u_accum (
    .clk             (clk),
    .rst             (rst),
    .ctl             (acc_ctl),
    .cfg             (cfg),
    .range_mm        (range_mm),
    .sample_valid    (sample_valid),
    .running_min     (acc_min),
    .any_in_window   (acc_any),
    .range_sum       (acc_sum),
    .in_window_count (acc_count),
    .in_band_count   (acc_band),
    .overflowed      (acc_ovf)
  );

  lawsc_div #(
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_START),
    .num   (acc_sum),
    .den   (acc_count),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  assign count_ext = {{lawsc_pkg::COUNT_OUT_W{1'b0}}, acc_count};
  assign band_ext  = {{lawsc_pkg::COUNT_OUT_W{1'b0}}, acc_band};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      min_found      <= acc_any;
      min_range_out  <= acc_any ? acc_min : '0;
      mean_range_out <= (acc_count == '0) ? '0 : div_quo;
      window_points  <= count_ext[lawsc_pkg::COUNT_OUT_W-1:0];
      band_points    <= band_ext[lawsc_pkg::COUNT_OUT_W-1:0];
      scan_overflow  <= acc_ovf;
    end
  end

  `LAWSC_ASSERT_SAME(a_idle_div_quiet, clk, rst, in_ready, !div_stat.busy)
  `LAWSC_ASSERT_NEXT(a_last_starts_div, clk, rst, in_take && last_sample, state == S_START)
  `LAWSC_ASSERT_NEXT(a_load_gives_result, clk, rst, load, out_valid && in_ready)
  `LAWSC_ASSERT_SAME(a_any_matches_count, clk, rst, 1'b1, acc_any == (acc_count != '0))

endmodule
